// File: sv/lam_pkg.sv
// ----------------------------------------------------------------------------
// lam_pkg
// Shared constants and codes for the LFO amplitude modulator.
// ----------------------------------------------------------------------------
package lam_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int POSITION_WIDTH_DEF = 48;
    localparam int PERIOD_WIDTH       = 32;
    localparam int GAIN_WIDTH         = 32;
    localparam int MODE_WIDTH         = 3;
    localparam int VOLUME_WIDTH       = 8;
    localparam int ADDR_WIDTH         = 5;
    localparam int DATA_WIDTH         = 64;
    localparam int FIFO_DEPTH         = 4;

    localparam logic [VOLUME_WIDTH-1:0] VOLUME_RESET = 8'd100;
    localparam logic [GAIN_WIDTH-1:0]   VOLUME_DIV   = 32'd100;

    // break threshold: d > P*95/100  <=>  20*d > 19*P
    localparam int BREAK_D_MUL = 20;
    localparam int BREAK_P_MUL = 19;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_VOLUME = 3'd0,
        MODE_SAW    = 3'd1,
        MODE_RSAW   = 3'd2,
        MODE_PAN    = 3'd3,
        MODE_BREAK  = 3'd4
    } lfo_mode_t;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_PERIOD = 2'd1,
        REG_PHASE  = 2'd2,
        REG_VOLUME = 2'd3
    } reg_index_t;

endpackage

// File: sv/lam_fifo.sv
// ----------------------------------------------------------------------------
// lam_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module lam_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lam_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule

// File: sv/lam_front.sv
// ----------------------------------------------------------------------------
// lam_front
// Phase pipeline: distance to the phase offset, remainder by the period one
// bit per stage, then per-channel gain numerator and denominator.
// ----------------------------------------------------------------------------
module lam_front #(
    parameter int SAMPLE_WIDTH   = lam_pkg::SAMPLE_WIDTH_DEF,
    parameter int POSITION_WIDTH = lam_pkg::POSITION_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [POSITION_WIDTH-1:0]           in_pos,
    input  logic signed [SAMPLE_WIDTH-1:0]      in_left,
    input  logic signed [SAMPLE_WIDTH-1:0]      in_right,
    input  logic [lam_pkg::MODE_WIDTH-1:0]      cfg_mode,
    input  logic [lam_pkg::PERIOD_WIDTH-1:0]    cfg_period,
    input  logic [POSITION_WIDTH-1:0]           cfg_phase,
    input  logic [lam_pkg::VOLUME_WIDTH-1:0]    cfg_volume,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      out_left,
    output logic signed [SAMPLE_WIDTH-1:0]      out_right,
    output logic [lam_pkg::GAIN_WIDTH-1:0]      out_lmul,
    output logic [lam_pkg::GAIN_WIDTH-1:0]      out_ldiv,
    output logic [lam_pkg::GAIN_WIDTH-1:0]      out_rmul,
    output logic [lam_pkg::GAIN_WIDTH-1:0]      out_rdiv
);

    localparam int PW = POSITION_WIDTH;
    localparam int NW = lam_pkg::PERIOD_WIDTH;
    localparam int GW = lam_pkg::GAIN_WIDTH;
    localparam int NS = PW + 3;
    localparam int BW = NW + 6;

    logic [NS-1:0]                  v_reg;
    logic                           advance;

    logic [PW-1:0]                  a_reg   [0:PW];
    logic [NW-1:0]                  rem_reg [0:PW];
    logic                           neg_reg [0:PW];
    logic signed [SAMPLE_WIDTH-1:0] l_reg   [0:PW+1];
    logic signed [SAMPLE_WIDTH-1:0] r_reg   [0:PW+1];

    logic [NW-1:0]                  d_reg;
    logic [NW-1:0]                  d_next;

    logic [GW-1:0]                  lmul_next;
    logic [GW-1:0]                  ldiv_next;
    logic [GW-1:0]                  rmul_next;
    logic [GW-1:0]                  rdiv_next;
    logic [GW-1:0]                  lmul_reg;
    logic [GW-1:0]                  ldiv_reg;
    logic [GW-1:0]                  rmul_reg;
    logic [GW-1:0]                  rdiv_reg;
    logic signed [SAMPLE_WIDTH-1:0] lo_reg;
    logic signed [SAMPLE_WIDTH-1:0] ro_reg;

    assign advance   = !v_reg[NS-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = v_reg[NS-1];
    assign out_left  = lo_reg;
    assign out_right = ro_reg;
    assign out_lmul  = lmul_reg;
    assign out_ldiv  = ldiv_reg;
    assign out_rmul  = rmul_reg;
    assign out_rdiv  = rdiv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (in_pos >= cfg_phase)
            begin
                a_reg[0] <= in_pos - cfg_phase;
            end
            else
            begin
                a_reg[0] <= cfg_phase - in_pos;
            end
            neg_reg[0] <= (in_pos < cfg_phase);
            rem_reg[0] <= '0;
            l_reg[0]   <= in_left;
            r_reg[0]   <= in_right;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= PW; k++)
        begin : g_mod
            logic [NW:0] trial;
            assign trial = {rem_reg[k-1], a_reg[k-1][PW-1]};
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    if (trial >= {1'b0, cfg_period})
                    begin
                        rem_reg[k] <= NW'(trial - {1'b0, cfg_period});
                    end
                    else
                    begin
                        rem_reg[k] <= trial[NW-1:0];
                    end
                    a_reg[k]   <= {a_reg[k-1][PW-2:0], 1'b0};
                    neg_reg[k] <= neg_reg[k-1];
                    l_reg[k]   <= l_reg[k-1];
                    r_reg[k]   <= r_reg[k-1];
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (neg_reg[PW] && (rem_reg[PW] != '0))
        begin
            d_next = cfg_period - rem_reg[PW];
        end
        else
        begin
            d_next = rem_reg[PW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_reg        <= d_next;
            l_reg[PW+1]  <= l_reg[PW];
            r_reg[PW+1]  <= r_reg[PW];
        end
    end

    always_comb
    begin
        logic [NW-1:0] q;
        logic [NW+1:0] q2;
        logic [NW+1:0] q3;
        logic [NW+1:0] dw;
        logic [BW-1:0] bd;
        logic [BW-1:0] bp;
        logic          lfo;
        q   = cfg_period >> 2;
        q2  = {2'b00, q} + {2'b00, q};
        q3  = q2 + {2'b00, q};
        dw  = {2'b00, d_reg};
        bd  = BW'(d_reg) * BW'(lam_pkg::BREAK_D_MUL);
        bp  = BW'(cfg_period) * BW'(lam_pkg::BREAK_P_MUL);
        lfo = (cfg_mode == lam_pkg::MODE_SAW) || (cfg_mode == lam_pkg::MODE_RSAW) ||
              (cfg_mode == lam_pkg::MODE_PAN) || (cfg_mode == lam_pkg::MODE_BREAK);
        lmul_next = GW'(1);
        ldiv_next = GW'(1);
        rmul_next = GW'(1);
        rdiv_next = GW'(1);
        if (!lfo)
        begin
            lmul_next = GW'(cfg_volume);
            rmul_next = GW'(cfg_volume);
            ldiv_next = lam_pkg::VOLUME_DIV;
            rdiv_next = lam_pkg::VOLUME_DIV;
        end
        else if (cfg_period != '0)
        begin
            case (cfg_mode)
                lam_pkg::MODE_SAW:
                begin
                    lmul_next = GW'(d_reg);
                    rmul_next = GW'(d_reg);
                    ldiv_next = GW'(cfg_period);
                    rdiv_next = GW'(cfg_period);
                end
                lam_pkg::MODE_RSAW:
                begin
                    lmul_next = GW'(cfg_period - d_reg);
                    rmul_next = GW'(cfg_period - d_reg);
                    ldiv_next = GW'(cfg_period);
                    rdiv_next = GW'(cfg_period);
                end
                lam_pkg::MODE_PAN:
                begin
                    if (d_reg < q)
                    begin
                        lmul_next = GW'(q - d_reg);
                        ldiv_next = GW'(q);
                    end
                    else if (dw < q2)
                    begin
                        lmul_next = GW'(d_reg - q);
                        ldiv_next = GW'(q);
                    end
                    else if (dw < q3)
                    begin
                        rmul_next = GW'(q3 - dw);
                        rdiv_next = GW'(q);
                    end
                    else
                    begin
                        rmul_next = GW'(dw - q3);
                        rdiv_next = GW'(q);
                    end
                end
                default:
                begin
                    if (bd > bp)
                    begin
                        lmul_next = '0;
                        rmul_next = '0;
                    end
                end
            endcase
        end
        if (ldiv_next == '0)
        begin
            lmul_next = GW'(1);
            ldiv_next = GW'(1);
        end
        if (rdiv_next == '0)
        begin
            rmul_next = GW'(1);
            rdiv_next = GW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lmul_reg <= lmul_next;
            ldiv_reg <= ldiv_next;
            rmul_reg <= rmul_next;
            rdiv_reg <= rdiv_next;
            lo_reg   <= l_reg[PW+1];
            ro_reg   <= r_reg[PW+1];
        end
    end

endmodule

// File: sv/lam_back.sv
// ----------------------------------------------------------------------------
// lam_back
// Scale pipeline: sample times gain, restoring divide one quotient bit per
// stage for both channels, then saturation.
// ----------------------------------------------------------------------------
module lam_back #(
    parameter int SAMPLE_WIDTH = lam_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_left,
    input  logic signed [SAMPLE_WIDTH-1:0] in_right,
    input  logic [lam_pkg::GAIN_WIDTH-1:0] in_lmul,
    input  logic [lam_pkg::GAIN_WIDTH-1:0] in_ldiv,
    input  logic [lam_pkg::GAIN_WIDTH-1:0] in_rmul,
    input  logic [lam_pkg::GAIN_WIDTH-1:0] in_rdiv,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_left,
    output logic signed [SAMPLE_WIDTH-1:0] out_right
);

    localparam int GW = lam_pkg::GAIN_WIDTH;
    localparam int QW = SAMPLE_WIDTH + GW;
    localparam int PWD = QW + 1;
    localparam int NS = QW + 2;

    logic [NS-1:0]   v_reg;
    logic            advance;

    logic [QW-1:0]   ln_reg  [0:QW];
    logic [QW-1:0]   rn_reg  [0:QW];
    logic [GW-1:0]   lr_reg  [0:QW];
    logic [GW-1:0]   rr_reg  [0:QW];
    logic [GW-1:0]   ld_reg  [0:QW];
    logic [GW-1:0]   rd_reg  [0:QW];
    logic            lneg_reg[0:QW];
    logic            rneg_reg[0:QW];

    logic signed [PWD-1:0] lprod;
    logic signed [PWD-1:0] rprod;
    logic signed [SAMPLE_WIDTH-1:0] lo_reg;
    logic signed [SAMPLE_WIDTH-1:0] ro_reg;

    function automatic logic [SAMPLE_WIDTH-1:0] sat(input logic [QW-1:0] mag,
                                                     input logic neg);
        logic [QW-1:0] maxv;
        logic [QW-1:0] negv;
        maxv = QW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
        negv = '0 - mag;
        if (!neg)
        begin
            sat = (mag > maxv) ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} : mag[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            sat = (mag > maxv + QW'(1)) ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                        : negv[SAMPLE_WIDTH-1:0];
        end
    endfunction

    assign advance   = !v_reg[NS-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = v_reg[NS-1];
    assign out_left  = lo_reg;
    assign out_right = ro_reg;

    assign lprod = PWD'(in_left) * $signed({1'b0, in_lmul});
    assign rprod = PWD'(in_right) * $signed({1'b0, in_rmul});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ln_reg[0]   <= lprod[PWD-1] ? QW'(-lprod) : QW'(lprod);
            rn_reg[0]   <= rprod[PWD-1] ? QW'(-rprod) : QW'(rprod);
            lneg_reg[0] <= lprod[PWD-1];
            rneg_reg[0] <= rprod[PWD-1];
            lr_reg[0]   <= '0;
            rr_reg[0]   <= '0;
            ld_reg[0]   <= in_ldiv;
            rd_reg[0]   <= in_rdiv;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++)
        begin : g_div
            logic [GW:0] ltrial;
            logic [GW:0] rtrial;
            logic        lq;
            logic        rq;
            assign ltrial = {lr_reg[k-1], ln_reg[k-1][QW-1]};
            assign rtrial = {rr_reg[k-1], rn_reg[k-1][QW-1]};
            assign lq     = (ltrial >= {1'b0, ld_reg[k-1]});
            assign rq     = (rtrial >= {1'b0, rd_reg[k-1]});
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    lr_reg[k]   <= lq ? GW'(ltrial - {1'b0, ld_reg[k-1]}) : ltrial[GW-1:0];
                    rr_reg[k]   <= rq ? GW'(rtrial - {1'b0, rd_reg[k-1]}) : rtrial[GW-1:0];
                    ln_reg[k]   <= {ln_reg[k-1][QW-2:0], lq};
                    rn_reg[k]   <= {rn_reg[k-1][QW-2:0], rq};
                    ld_reg[k]   <= ld_reg[k-1];
                    rd_reg[k]   <= rd_reg[k-1];
                    lneg_reg[k] <= lneg_reg[k-1];
                    rneg_reg[k] <= rneg_reg[k-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lo_reg <= sat(ln_reg[QW], lneg_reg[QW]);
            ro_reg <= sat(rn_reg[QW], rneg_reg[QW]);
        end
    end

endmodule

// File: sv/lfo_amplitude_modulator_unit.sv
// ----------------------------------------------------------------------------
// lfo_amplitude_modulator_unit
// Stereo tremolo / auto-pan with APB configuration and queue-style ports.
// ----------------------------------------------------------------------------
// Takes one stereo item per clock while full is low, sustained as long as
// results are popped, and returns one result per item in order. An item
// passes through the bit-per-stage remainder pipeline in the phase front
// end, the middle queue, the bit-per-stage gain divider in the scale back
// end and the output queue before its result appears on the output ports.
// Configuration registers sit at byte addresses 0, 8, 16 and 24 (mode,
// period, phase, volume) and must only be written while no item is in flight.
module lfo_amplitude_modulator_unit #(
    parameter int SAMPLE_WIDTH   = lam_pkg::SAMPLE_WIDTH_DEF,
    parameter int POSITION_WIDTH = lam_pkg::POSITION_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lam_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [lam_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic [lam_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic [POSITION_WIDTH-1:0]          play_position,
    input  logic signed [SAMPLE_WIDTH-1:0]     left_in,
    input  logic signed [SAMPLE_WIDTH-1:0]     right_in,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [SAMPLE_WIDTH-1:0]     left_out,
    output logic signed [SAMPLE_WIDTH-1:0]     right_out
);

    localparam int GW = lam_pkg::GAIN_WIDTH;
    localparam int DW = lam_pkg::DATA_WIDTH;
    localparam int MW = 2 * SAMPLE_WIDTH + 4 * GW;
    localparam int OW = 2 * SAMPLE_WIDTH;

    logic [lam_pkg::MODE_WIDTH-1:0]   mode_reg;
    logic [lam_pkg::PERIOD_WIDTH-1:0] period_reg;
    logic [POSITION_WIDTH-1:0]        phase_reg;
    logic [lam_pkg::VOLUME_WIDTH-1:0] volume_reg;
    logic                             cfg_wr;
    lam_pkg::reg_index_t              cfg_idx;

    logic                             front_ready;
    logic                             front_valid;
    logic signed [SAMPLE_WIDTH-1:0]   front_left;
    logic signed [SAMPLE_WIDTH-1:0]   front_right;
    logic [GW-1:0]                    front_lmul;
    logic [GW-1:0]                    front_ldiv;
    logic [GW-1:0]                    front_rmul;
    logic [GW-1:0]                    front_rdiv;

    logic                             mid_full;
    logic                             mid_empty;
    logic [MW-1:0]                    mid_rdata;
    logic                             back_ready;
    logic                             back_valid;
    logic signed [SAMPLE_WIDTH-1:0]   back_left;
    logic signed [SAMPLE_WIDTH-1:0]   back_right;
    logic                             out_full;
    logic [OW-1:0]                    out_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = lam_pkg::reg_index_t'(paddr[lam_pkg::ADDR_WIDTH-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lam_pkg::MODE_VOLUME;
            period_reg <= '0;
            phase_reg  <= '0;
            volume_reg <= lam_pkg::VOLUME_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                lam_pkg::REG_MODE:   mode_reg   <= pwdata[lam_pkg::MODE_WIDTH-1:0];
                lam_pkg::REG_PERIOD: period_reg <= pwdata[lam_pkg::PERIOD_WIDTH-1:0];
                lam_pkg::REG_PHASE:  phase_reg  <= pwdata[POSITION_WIDTH-1:0];
                lam_pkg::REG_VOLUME: volume_reg <= pwdata[lam_pkg::VOLUME_WIDTH-1:0];
                default:             mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            lam_pkg::REG_MODE:   prdata = DW'(mode_reg);
            lam_pkg::REG_PERIOD: prdata = DW'(period_reg);
            lam_pkg::REG_PHASE:  prdata = DW'(phase_reg);
            lam_pkg::REG_VOLUME: prdata = DW'(volume_reg);
            default:             prdata = '0;
        endcase
    end

    assign full = !front_ready;

    lam_front #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (push),
        .in_ready   (front_ready),
        .in_pos     (play_position),
        .in_left    (left_in),
        .in_right   (right_in),
        .cfg_mode   (mode_reg),
        .cfg_period (period_reg),
        .cfg_phase  (phase_reg),
        .cfg_volume (volume_reg),
        .out_valid  (front_valid),
        .out_ready  (!mid_full),
        .out_left   (front_left),
        .out_right  (front_right),
        .out_lmul   (front_lmul),
        .out_ldiv   (front_ldiv),
        .out_rmul   (front_rmul),
        .out_rdiv   (front_rdiv)
    );

    lam_fifo #(
        .WIDTH (MW),
        .DEPTH (lam_pkg::FIFO_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .full  (mid_full),
        .wdata ({front_left, front_right, front_lmul, front_ldiv, front_rmul, front_rdiv}),
        .pop   (back_ready),
        .empty (mid_empty),
        .rdata (mid_rdata)
    );

    lam_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty),
        .in_ready  (back_ready),
        .in_left   (mid_rdata[MW-1 -: SAMPLE_WIDTH]),
        .in_right  (mid_rdata[MW-SAMPLE_WIDTH-1 -: SAMPLE_WIDTH]),
        .in_lmul   (mid_rdata[4*GW-1 -: GW]),
        .in_ldiv   (mid_rdata[3*GW-1 -: GW]),
        .in_rmul   (mid_rdata[2*GW-1 -: GW]),
        .in_rdiv   (mid_rdata[GW-1:0]),
        .out_valid (back_valid),
        .out_ready (!out_full),
        .out_left  (back_left),
        .out_right (back_right)
    );

    lam_fifo #(
        .WIDTH (OW),
        .DEPTH (lam_pkg::FIFO_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_valid),
        .full  (out_full),
        .wdata ({back_left, back_right}),
        .pop   (pop),
        .empty (empty),
        .rdata (out_rdata)
    );

    assign left_out  = out_rdata[OW-1 -: SAMPLE_WIDTH];
    assign right_out = out_rdata[SAMPLE_WIDTH-1:0];

    a_back_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (back_valid && out_full) |=> (back_valid && $stable(back_left) && $stable(back_right)))
        else $error("back end result lost while output queue full");

    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && mid_full) |=> (front_valid && $stable(front_lmul)))
        else $error("front end item lost while middle queue full");

    a_full_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (!front_valid) |-> !full)
        else $error("input stalled with empty front end output");

endmodule

// File: tb/lfo_amplitude_modulator_unit_tb.sv
// ----------------------------------------------------------------------------
// lfo_amplitude_modulator_unit_tb
// The test programs each LFO mode, period and phase setting over APB, then
// streams stereo items with random idle gaps on both sides. A predictor
// works out each expected result. Every result popped from the block is
// compared, in order, with the oldest expected result.
// ----------------------------------------------------------------------------
module lfo_amplitude_modulator_unit_tb;

    localparam int SW = lam_pkg::SAMPLE_WIDTH_DEF;
    localparam int PW = lam_pkg::POSITION_WIDTH_DEF;
    localparam int AW = lam_pkg::ADDR_WIDTH;
    localparam int DW = lam_pkg::DATA_WIDTH;
    localparam int DRAIN_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } stereo_t;

    class sample_scoreboard;
        stereo_t pending[$];
        int      errors;
        int      checked;

        function void note_input(stereo_t s);
            pending.push_back(s);
        endfunction

        function void check_result(stereo_t got);
            stereo_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no expected item", 0, got.left);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.left !== want.left)
                report_mismatch("left_out", want.left, got.left);
            if (got.right !== want.right)
                report_mismatch("right_out", want.right, got.right);
        endfunction

        function void report_mismatch(string what, int want, int got);
            errors++;
            if (errors <= 40)
                $display("error: %s expected %0d got %0d", what, want, got);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [AW-1:0]          paddr;
    logic [DW-1:0]          pwdata;
    logic [DW-1:0]          prdata;
    logic                   pready;
    logic                   push;
    logic                   full;
    logic [PW-1:0]          play_position;
    logic signed [SW-1:0]   left_in;
    logic signed [SW-1:0]   right_in;
    logic                   empty;
    logic                   pop;
    logic signed [SW-1:0]   left_out;
    logic signed [SW-1:0]   right_out;

    lfo_amplitude_modulator_unit uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .play_position(play_position),
        .left_in(left_in), .right_in(right_in),
        .empty(empty), .pop(pop), .left_out(left_out), .right_out(right_out)
    );

    sample_scoreboard sb;

    logic [lam_pkg::MODE_WIDTH-1:0]   cur_mode;
    logic [lam_pkg::PERIOD_WIDTH-1:0] cur_period;
    logic [PW-1:0]                    cur_phase;
    logic [lam_pkg::VOLUME_WIDTH-1:0] cur_volume;

    bit  quiet;
    int  idle_cycles;
    int  pushed;
    bit  timed_out;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [SW-1:0] scale_sample(
        logic signed [SW-1:0] s, longint unsigned mul, longint unsigned div);
        longint r;
        r = s;
        if (div != 0)
            r = (longint'(s) * longint'(mul)) / longint'(div);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[SW-1:0];
    endfunction

    function automatic stereo_t modulate(logic [PW-1:0] pos, stereo_t s);
        longint unsigned p, d, q, lm, ld, rm, rd;
        stereo_t o;
        p = cur_period;
        lm = 1; ld = 1; rm = 1; rd = 1;
        if (!(cur_mode inside {lam_pkg::MODE_SAW, lam_pkg::MODE_RSAW, lam_pkg::MODE_PAN,
                               lam_pkg::MODE_BREAK}))
        begin
            lm = cur_volume; rm = cur_volume; ld = 100; rd = 100;
        end
        else if (p != 0)
        begin
            if (pos >= cur_phase)
                d = (pos - cur_phase) % p;
            else
                d = (p - ((cur_phase - pos) % p)) % p;
            q = p / 4;
            case (cur_mode)
                lam_pkg::MODE_SAW:
                begin
                    lm = d; rm = d; ld = p; rd = p;
                end
                lam_pkg::MODE_RSAW:
                begin
                    lm = p - d; rm = p - d; ld = p; rd = p;
                end
                lam_pkg::MODE_PAN:
                begin
                    if (d < q)
                    begin
                        lm = q - d; ld = q;
                    end
                    else if (d - q < q)
                    begin
                        lm = d - q; ld = q;
                    end
                    else if (d - 2 * q < q)
                    begin
                        rm = q - (d - 2 * q); rd = q;
                    end
                    else
                    begin
                        rm = d - 3 * q; rd = q;
                    end
                end
                default:
                    if (d > p * 95 / 100)
                    begin
                        lm = 0; rm = 0;
                    end
            endcase
        end
        o.left  = scale_sample(s.left, lm, ld);
        o.right = scale_sample(s.right, rm, rd);
        return o;
    endfunction

    task automatic write_reg(lam_pkg::reg_index_t idx, logic [DW-1:0] val);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = AW'(8 * idx); pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            lam_pkg::REG_MODE:   cur_mode = val[lam_pkg::MODE_WIDTH-1:0];
            lam_pkg::REG_PERIOD: cur_period = val[lam_pkg::PERIOD_WIDTH-1:0];
            lam_pkg::REG_PHASE:  cur_phase = val[PW-1:0];
            default:             cur_volume = val[lam_pkg::VOLUME_WIDTH-1:0];
        endcase
    endtask

    task automatic configure(logic [2:0] m, logic [31:0] p, logic [PW-1:0] ph,
                             logic [7:0] v);
        write_reg(lam_pkg::REG_MODE, {$urandom, $urandom} & ~64'h7 | m);
        write_reg(lam_pkg::REG_PERIOD, {32'($urandom), p});
        write_reg(lam_pkg::REG_PHASE, {16'($urandom), ph});
        write_reg(lam_pkg::REG_VOLUME, {$urandom, 24'($urandom), v});
    endtask

    task automatic send_item(logic [PW-1:0] pos, logic signed [SW-1:0] l,
                             logic signed [SW-1:0] r);
        stereo_t s;
        if (!quiet && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 18)) @(negedge clk);
        push = 1'b1; play_position = pos; left_in = l; right_in = r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        s.left = l; s.right = r;
        sb.note_input(modulate(pos, s));
        pushed++;
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic drain;
        int n;
        n = 0;
        while (sb.pending.size() != 0 && !timed_out)
            @(negedge clk);
        while (n < DRAIN_CYCLES)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    function automatic logic signed [SW-1:0] rand_sample;
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [PW-1:0] rand_pos;
        if ($urandom_range(0, 3) == 0)
            return PW'({$urandom, $urandom});
        return PW'(cur_phase + {$urandom, $urandom} % (longint'(cur_period) * 3 + 7)
                   - cur_period);
    endfunction

    always @(posedge clk)
    begin
        stereo_t got;
        if (rst_n && pop && !empty)
        begin
            got.left = left_out; got.right = right_out;
            sb.check_result(got);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (quiet)
            pop <= 1'b1;
        else if (!pop)
            pop <= ($urandom_range(0, 3) != 0);
        else if ($urandom_range(0, 9) == 0)
            pop <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (psel && penable) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("lfo_amplitude_modulator_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] periods [8];
        sb = new();
        rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0; push = 1'b0;
        play_position = '0; left_in = '0; right_in = '0;
        quiet = 1'b0; pushed = 0; idle_cycles = 0; timed_out = 1'b0;
        cur_mode = lam_pkg::MODE_VOLUME; cur_period = '0; cur_phase = '0;
        cur_volume = lam_pkg::VOLUME_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // reset settings, then extremes in every mode
        send_item(48'h0, 16'sh7fff, 16'sh8000);
        send_item({PW{1'b1}}, 16'sh8000, 16'sh7fff);
        drain();
        configure(lam_pkg::MODE_VOLUME, 32'd0, 48'd0, 8'd255);
        send_item(48'd5, 16'sh7fff, 16'sh8000);
        send_item(48'd5, 16'sh0, -16'sd1);
        drain();
        configure(lam_pkg::MODE_VOLUME, 32'd0, 48'd0, 8'd0);
        send_item(48'd5, 16'sh7fff, 16'sh8000);
        drain();
        configure(lam_pkg::MODE_SAW, 32'd0, 48'd0, 8'd100);
        send_item(48'd3, 16'sh7fff, 16'sh8000);
        drain();
        configure(lam_pkg::MODE_SAW, 32'd10, 48'd100, 8'd100);
        send_item(48'd105, 16'sh7fff, 16'sh8000);
        send_item(48'd3, 16'sh7fff, 16'sh8000);
        drain();
        configure(lam_pkg::MODE_RSAW, 32'hffffffff, {PW{1'b1}}, 8'd1);
        send_item(48'd0, 16'sh7fff, 16'sh8000);
        send_item({PW{1'b1}}, 16'sh7fff, 16'sh8000);
        drain();
        configure(lam_pkg::MODE_PAN, 32'd3, 48'd0, 8'd100);
        send_item(48'd1, 16'sh7fff, 16'sh8000);
        drain();
        configure(lam_pkg::MODE_PAN, 32'd7, 48'd2, 8'd100);
        for (int i = 0; i < 7; i++)
            send_item(48'(i), 16'sh7fff, 16'sh8000);
        drain();
        configure(lam_pkg::MODE_BREAK, 32'd100, 48'd0, 8'd100);
        send_item(48'd95, 16'sh1234, 16'sh8000);
        send_item(48'd96, 16'sh1234, 16'sh8000);
        drain();
        configure(3'd7, 32'd9, 48'd0, 8'd50);
        send_item(48'd1, 16'sh7fff, 16'sh8000);
        drain();

        periods = '{32'd0, 32'd1, 32'd3, 32'd4, 32'd17, 32'd100, 32'd1000,
                    32'hffffffff};
        for (int ph = 0; ph < 28; ph++)
        begin
            configure(3'($urandom_range(0, 7)), periods[$urandom_range(0, 7)],
                      ($urandom_range(0, 1) ? PW'({$urandom, $urandom}) :
                       48'($urandom_range(0, 2000))), 8'($urandom));
            if (ph == 27)
                quiet = 1'b1;
            repeat (50)
                send_item(rand_pos(), rand_sample(), rand_sample());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("Covered %0d items over all modes, extreme periods and phases.",
                     pushed);
            $display("lfo_amplitude_modulator_unit: match");
        end
        else
        begin
            $display("Covered %0d items; %0d errors, %0d left over.",
                     pushed, sb.errors, sb.pending.size());
            $display("lfo_amplitude_modulator_unit: mismatch");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/lam_pkg.sv
sv/lam_fifo.sv
sv/lam_front.sv
sv/lam_back.sv
sv/lfo_amplitude_modulator_unit.sv
tb/lfo_amplitude_modulator_unit_tb.sv
